// ----- rtl/core/pet_pkg.sv -----
package pet_pkg;

	localparam int CFG_W     = 32;
	localparam int ESC_W     = 31;
	localparam int LIM_W     = 16;
	localparam int CNT_INT_W = 17;
	localparam int ADDR_W    = 5;

	localparam logic [CFG_W-1:0] C_REAL_RST          = 32'd152122373;
	localparam logic [CFG_W-1:0] C_IMAG_RST          = 32'd0;
	localparam logic [CFG_W-1:0] P_REAL_RST          = 32'hF800_0000;
	localparam logic [CFG_W-1:0] P_IMAG_RST          = 32'd0;
	localparam logic [ESC_W-1:0] ESCAPE_LIMIT_RST    = 31'd1073741824;
	localparam logic [LIM_W-1:0] ITERATION_LIMIT_RST = 16'd500;

	typedef enum logic [2:0] {
		REG_C_REAL          = 3'd0,
		REG_C_IMAG          = 3'd1,
		REG_P_REAL          = 3'd2,
		REG_P_IMAG          = 3'd3,
		REG_ESCAPE_LIMIT    = 3'd4,
		REG_ITERATION_LIMIT = 3'd5
	} pet_reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] c_real;
		logic [CFG_W-1:0] c_imag;
		logic [CFG_W-1:0] p_real;
		logic [CFG_W-1:0] p_imag;
		logic [ESC_W-1:0] escape_limit;
		logic [LIM_W-1:0] iteration_limit;
	} pet_cfg_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} pet_state_t;

endpackage

// ----- rtl/core/pet_mul.sv -----
module pet_mul #(
	parameter int W = 32,
	parameter int F = 28
) (
	input  logic                clk,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	output logic signed [W-1:0] res
);

	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	logic signed [2*W-1:0] prod_s1;
	logic signed [2*W-1:0] shifted;
	logic                  fits;
	logic signed [W-1:0]   res_s2;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	// floor shift, then clamp to the value range
	assign shifted = prod_s1 >>> F;
	assign fits    = (&shifted[2*W-1:W-1]) | ~(|shifted[2*W-1:W-1]);

	always_ff @(posedge clk) begin
		if (fits) begin
			res_s2 <= shifted[W-1:0];
		end else begin
			res_s2 <= shifted[2*W-1] ? MIN_V : MAX_V;
		end
	end

	assign res = res_s2;

endmodule

// ----- rtl/core/pet_cfg.sv -----
module pet_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pet_pkg::ADDR_W-1:0]  paddr,
	input  logic [pet_pkg::CFG_W-1:0]   pwdata,
	output logic [pet_pkg::CFG_W-1:0]   prdata,
	output logic                        pready,
	output pet_pkg::pet_cfg_t           cfg
);

	import pet_pkg::*;

	pet_cfg_t     cfg_q;
	pet_reg_idx_t idx;
	logic         wr_en;

	assign idx    = pet_reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real          <= C_REAL_RST;
			cfg_q.c_imag          <= C_IMAG_RST;
			cfg_q.p_real          <= P_REAL_RST;
			cfg_q.p_imag          <= P_IMAG_RST;
			cfg_q.escape_limit    <= ESCAPE_LIMIT_RST;
			cfg_q.iteration_limit <= ITERATION_LIMIT_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_C_REAL:          cfg_q.c_real          <= pwdata;
				REG_C_IMAG:          cfg_q.c_imag          <= pwdata;
				REG_P_REAL:          cfg_q.p_real          <= pwdata;
				REG_P_IMAG:          cfg_q.p_imag          <= pwdata;
				REG_ESCAPE_LIMIT:    cfg_q.escape_limit    <= pwdata[ESC_W-1:0];
				REG_ITERATION_LIMIT: cfg_q.iteration_limit <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_C_REAL:          prdata = cfg_q.c_real;
			REG_C_IMAG:          prdata = cfg_q.c_imag;
			REG_P_REAL:          prdata = cfg_q.p_real;
			REG_P_IMAG:          prdata = cfg_q.p_imag;
			REG_ESCAPE_LIMIT:    prdata = CFG_W'(cfg_q.escape_limit);
			REG_ITERATION_LIMIT: prdata = CFG_W'(cfg_q.iteration_limit);
			default:             prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/phoenix_escape_time_core.sv -----
// Phoenix escape-time engine for one pixel. Pulse start with the starting value while busy is
// low; the block then iterates z = z1*z1 + c + p*z2 on a single shared fixed-point multiplier
// and answers with iter_count and inside_res on a one-cycle done strobe. The receiver cannot
// stall; the result stays on the ports until the next item finishes. The multiplier forms
// seven products per iteration, and busy stays high until the final magnitude check ends the
// item; the number of iterations performed is at most iteration_limit + 1. A new start is
// taken in the same cycle as done.
module phoenix_escape_time_core #(
	parameter int VALUE_WIDTH   = 32,
	parameter int FRACTION_BITS = 28,
	parameter int COUNT_WIDTH   = 17
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [VALUE_WIDTH-1:0]     start_real,
	input  logic signed [VALUE_WIDTH-1:0]     start_imag,
	output logic                              done,
	output logic [COUNT_WIDTH-1:0]            iter_count,
	output logic                              inside_res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [pet_pkg::ADDR_W-1:0]        paddr,
	input  logic [pet_pkg::CFG_W-1:0]         pwdata,
	output logic [pet_pkg::CFG_W-1:0]         prdata,
	output logic                              pready
);

	import pet_pkg::*;

	localparam int W    = VALUE_WIDTH;
	localparam int CMPW = ((W > ESC_W) ? W : ESC_W) + 1;

	localparam logic [W-1:0] MAX_V = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

	// step of one iteration: products issued at 0..6, results taken from the multiplier output at later steps
	localparam logic [3:0] STP_XX    = 4'd0;
	localparam logic [3:0] STP_YY    = 4'd1;
	localparam logic [3:0] STP_XY    = 4'd2;
	localparam logic [3:0] STP_CHECK = 4'd3;
	localparam logic [3:0] STP_SQIM  = 4'd4;
	localparam logic [3:0] STP_T0    = 4'd5;
	localparam logic [3:0] STP_PZRE  = 4'd6;
	localparam logic [3:0] STP_T2    = 4'd7;
	localparam logic [3:0] STP_PZIM  = 4'd8;
	localparam logic [3:0] STP_WRITE = 4'd9;

	function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_add = s[W] ? MIN_V : MAX_V;
		end else begin
			sat_add = s[W-1:0];
		end
	endfunction

	function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} - {b[W-1], b};
		if (s[W] != s[W-1]) begin
			sat_sub = s[W] ? MIN_V : MAX_V;
		end else begin
			sat_sub = s[W-1:0];
		end
	endfunction

	pet_cfg_t cfg;

	pet_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic signed [W-1:0] cr, ci, pr, pi;

	assign cr = W'(cfg.c_real);
	assign ci = W'(cfg.c_imag);
	assign pr = W'(cfg.p_real);
	assign pi = W'(cfg.p_imag);

	pet_state_t state_q, state_d;
	logic [3:0] step_q, step_d;
	logic       accept, finish, go;
	logic       done_q;

	logic signed [W-1:0] z1re_q, z1im_q, z2re_q, z2im_q;
	logic signed [W-1:0] xx_q, sqre_q, sqim_q, are_q, aim_q;
	logic signed [W-1:0] t0_q, t2_q, pzre_q, pzim_q, nzre_q;
	logic [CNT_INT_W-1:0] count_q;
	logic [CNT_INT_W-1:0] res_count_q;
	logic                 inside_q;

	logic signed [W-1:0]    op_a, op_b, mres;
	logic signed [W-1:0]    norm;
	logic signed [CMPW-1:0] norm_ext;
	logic signed [CMPW-1:0] esc_ext;
	logic [CNT_INT_W-1:0]   lim_ext;

	pet_mul #(
		.W (W),
		.F (FRACTION_BITS)
	) u_mul (
		.clk (clk),
		.a   (op_a),
		.b   (op_b),
		.res (mres)
	);

	always_comb begin
		unique case (step_q)
			STP_XX:    begin op_a = z1re_q; op_b = z1re_q; end
			STP_YY:    begin op_a = z1im_q; op_b = z1im_q; end
			STP_XY:    begin op_a = z1re_q; op_b = z1im_q; end
			STP_CHECK: begin op_a = pr;     op_b = z2re_q; end
			STP_SQIM:  begin op_a = pi;     op_b = z2im_q; end
			STP_T0:    begin op_a = pr;     op_b = z2im_q; end
			STP_PZRE:  begin op_a = pi;     op_b = z2re_q; end
			default:   begin op_a = z1re_q; op_b = z1re_q; end
		endcase
	end

	// escape and limit test, with yy arriving from the multiplier
	assign norm     = sat_add(xx_q, mres);
	assign norm_ext = CMPW'(norm);
	assign esc_ext  = CMPW'(cfg.escape_limit);
	assign lim_ext  = CNT_INT_W'(cfg.iteration_limit);
	assign go       = (norm_ext < esc_ext) && (count_q <= lim_ext);

	assign busy   = (state_q == ST_RUN);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			done_q  <= finish;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_RUN;
					step_d  = STP_XX;
				end
			end
			ST_RUN: begin
				step_d = step_q + 4'd1;
				if (step_q == STP_CHECK && !go) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else if (step_q == STP_WRITE) begin
					step_d = STP_XX;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z1re_q  <= start_real;
			z1im_q  <= start_imag;
			z2re_q  <= '0;
			z2im_q  <= '0;
			count_q <= '0;
		end else if (busy) begin
			unique case (step_q)
				STP_XY: begin
					xx_q <= mres;
				end
				STP_CHECK: begin
					sqre_q <= sat_sub(xx_q, mres);
				end
				STP_SQIM: begin
					sqim_q <= sat_add(mres, mres);
					are_q  <= sat_add(sqre_q, cr);
				end
				STP_T0: begin
					t0_q  <= mres;
					aim_q <= sat_add(sqim_q, ci);
				end
				STP_PZRE: begin
					pzre_q <= sat_sub(t0_q, mres);
				end
				STP_T2: begin
					t2_q   <= mres;
					nzre_q <= sat_add(are_q, pzre_q);
				end
				STP_PZIM: begin
					pzim_q <= sat_add(t2_q, mres);
				end
				STP_WRITE: begin
					z2re_q  <= z1re_q;
					z2im_q  <= z1im_q;
					z1re_q  <= nzre_q;
					z1im_q  <= sat_add(aim_q, pzim_q);
					count_q <= count_q + 1'b1;
				end
				default: ;
			endcase
		end
		if (finish) begin
			res_count_q <= count_q;
			inside_q    <= (count_q >= lim_ext);
		end
	end

	assign done       = done_q;
	assign iter_count = COUNT_WIDTH'(res_count_q);
	assign inside_res = inside_q;

endmodule
